// File: design/compound_frame_build_check_top_defines.svh
// Assertion macros for the compound frame build/check block.
`ifndef COMPOUND_FRAME_BUILD_CHECK_TOP_DEFINES_SVH
`define COMPOUND_FRAME_BUILD_CHECK_TOP_DEFINES_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define CFBC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cfbc assertion failed");

// Next-cycle implication, clocked on clk_i, off during reset.
`define CFBC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cfbc assertion failed");

`endif

// File: design/cfbc_pkg.sv
// Constants, status codes and CRC-8 function for the compound frame block.
package cfbc_pkg;

  localparam logic [7:0] CRC_POLY      = 8'h2F;
  localparam logic [7:0] CRC_INIT      = 8'hFF;
  localparam logic [7:0] CRC_XOROUT    = 8'hFF;
  localparam logic [2:0] TYPE_COMPOUND = 3'b001;

  localparam int PAY_W    = 53;
  localparam int PAY_HI_W = 35;
  localparam int PAY_LO_W = 18;

  localparam logic REQ_BUILD = 1'b0;
  localparam logic REQ_CHECK = 1'b1;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_TYPE  = 3'd1;
  localparam logic [2:0] ST_NO_LOCK   = 3'd2;
  localparam logic [2:0] ST_ARQ_SET   = 3'd3;
  localparam logic [2:0] ST_CRC_ERR   = 3'd4;
  localparam logic [2:0] ST_BAD_INDEX = 3'd5;

  // CRC-8 over a 64-bit span, MSB first; unrolls to an XOR network
  function automatic logic [7:0] crc8_span(input logic [63:0] span);
    logic [7:0] c;
    logic       fb;
    c = CRC_INIT;
    for (int i = 63; i >= 0; i--) begin
      fb = c[7] ^ span[i];
      c  = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return c ^ CRC_XOROUT;
  endfunction

endpackage

// File: design/compound_frame_build_check_top.sv
// Top level: builds or checks one 72-bit compound frame per word.
//
// Input channel (in_valid_i / in_ready_o) carries one request word: a build
// (req_type_i = 0) with payload, language, frame index and count, or a check
// (req_type_i = 1) with a received frame split into high and low parts.
// Output channel (out_valid_o / out_ready_i) returns one result word per
// request: status, built frame (zero on check), CRC and decoded fields.
// A word accepted into the input register moves on to the result register,
// which drives out_valid_o, once that register is free. The path is
// an input register, then the frame/CRC logic, then the result register.
// One word per cycle is sustained while out_ready_i is high; the CRC over the
// 64-bit span is a single XOR network between the two registers.
// When the receiver stalls, the result register holds its word and the
// input register fills; in_ready_o drops only once both are occupied.
// Reset clears both valid flags; no word is lost or repeated across a stall.
`include "compound_frame_build_check_top_defines.svh"

module compound_frame_build_check_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        req_type_i,
  input  logic [63:0] rx_frame_high_i,
  input  logic [7:0]  rx_frame_low_i,
  input  logic [cfbc_pkg::PAY_W-1:0] tx_payload_i,
  input  logic [2:0]  tx_lang_i,
  input  logic [2:0]  frame_index_i,
  input  logic [3:0]  frame_count_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [63:0] tx_frame_high_o,
  output logic [7:0]  tx_frame_low_o,
  output logic [7:0]  crc_value_o,
  output logic [2:0]  lang_out_o,
  output logic [2:0]  seq_field_out_o,
  output logic [cfbc_pkg::PAY_W-1:0] payload_out_o
);
  import cfbc_pkg::*;

  // input register
  logic              s1_valid_q;
  logic              req_q;
  logic [63:0]       rxh_q;
  logic [7:0]        rxl_q;
  logic [PAY_W-1:0]  pay_q;
  logic [2:0]        lang_q;
  logic [2:0]        idx_q;
  logic [3:0]        cnt_q;

  // result register
  logic              s2_valid_q;
  logic [2:0]        status_q, status_d;
  logic [63:0]       txh_q, txh_d;
  logic [7:0]        txl_q, txl_d;
  logic [7:0]        crc_q, crc_d;
  logic [2:0]        lang_out_q, lang_out_d;
  logic [2:0]        seq_q, seq_d;
  logic [PAY_W-1:0]  pay_out_q, pay_out_d;

  logic s2_ready, s1_ready;

  assign s2_ready   = !s2_valid_q || out_ready_i;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;

  // frame logic
  logic        idx_bad;
  logic [3:0]  cnt_m1;
  logic [2:0]  b_seq;
  logic [63:0] b_hi;
  logic [7:0]  b_lo;
  logic [63:0] span;
  logic [7:0]  crc;

  always_comb begin
    idx_bad = {1'b0, idx_q} >= cnt_q;
    cnt_m1  = cnt_q - 4'd1;
    b_seq   = (idx_q == 3'd0) ? cnt_m1[2:0] : idx_q;
    b_hi    = {TYPE_COMPOUND, b_seq, lang_q, 8'h00, 1'b0,
               pay_q[PAY_W-1:PAY_LO_W], 1'b1, pay_q[PAY_LO_W-1:8]};
    b_lo    = pay_q[7:0];
    if (req_q == REQ_CHECK) begin
      span = {rxh_q[63:55], rxh_q[46:0], rxl_q};
    end else begin
      span = {b_hi[63:55], b_hi[46:0], b_lo};
    end
    crc = crc8_span(span);
  end

  always_comb begin
    status_d   = ST_OK;
    txh_d      = '0;
    txl_d      = '0;
    crc_d      = crc;
    lang_out_d = '0;
    seq_d      = '0;
    pay_out_d  = '0;
    if (req_q == REQ_CHECK) begin
      lang_out_d = rxh_q[57:55];
      seq_d      = rxh_q[60:58];
      pay_out_d  = {rxh_q[45:11], rxh_q[9:0], rxl_q};
      priority if (rxh_q[63:61] != TYPE_COMPOUND) begin
        status_d = ST_BAD_TYPE;
      end else if (!rxh_q[10]) begin
        status_d = ST_NO_LOCK;
      end else if (rxh_q[46]) begin
        status_d = ST_ARQ_SET;
      end else if (rxh_q[54:47] != crc) begin
        status_d = ST_CRC_ERR;
      end else begin
        status_d = ST_OK;
      end
    end else if (idx_bad) begin
      status_d = ST_BAD_INDEX;
      crc_d    = '0;
    end else begin
      txh_d      = {b_hi[63:55], crc, b_hi[46:0]};
      txl_d      = b_lo;
      lang_out_d = lang_q;
      seq_d      = b_seq;
      pay_out_d  = pay_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      req_q  <= req_type_i;
      rxh_q  <= rx_frame_high_i;
      rxl_q  <= rx_frame_low_i;
      pay_q  <= tx_payload_i;
      lang_q <= tx_lang_i;
      idx_q  <= frame_index_i;
      cnt_q  <= frame_count_i;
    end
    if (s2_ready && s1_valid_q) begin
      status_q   <= status_d;
      txh_q      <= txh_d;
      txl_q      <= txl_d;
      crc_q      <= crc_d;
      lang_out_q <= lang_out_d;
      seq_q      <= seq_d;
      pay_out_q  <= pay_out_d;
    end
  end

  assign out_valid_o     = s2_valid_q;
  assign status_o        = status_q;
  assign tx_frame_high_o = txh_q;
  assign tx_frame_low_o  = txl_q;
  assign crc_value_o     = crc_q;
  assign lang_out_o      = lang_out_q;
  assign seq_field_out_o = seq_q;
  assign payload_out_o   = pay_out_q;

  `CFBC_ASSERT_NOW(a_bad_index_zero,
    out_valid_o && status_o == ST_BAD_INDEX,
    crc_value_o == 8'h00 && payload_out_o == '0 && tx_frame_high_o == 64'h0)
  `CFBC_ASSERT_NOW(a_built_frame_fixed,
    out_valid_o && tx_frame_high_o != 64'h0,
    status_o == ST_OK && tx_frame_high_o[63:61] == TYPE_COMPOUND &&
    tx_frame_high_o[10] && !tx_frame_high_o[46])
  `CFBC_ASSERT_NOW(a_ready_when_empty, !out_valid_o, in_ready_o)
  `CFBC_ASSERT_NEXT(a_s1_holds_on_stall, s1_valid_q && !s2_ready, s1_valid_q)

endmodule
